// ===== sv/tli_pkg.sv =====
// shared types and constants for the table linear interpolator
package tli_pkg;
	localparam int MaxPoints = 64;
	localparam int IdxW = $clog2(MaxPoints);
	localparam int CntW = 7;
	localparam int QDepth = 2;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FEW = 2'd1,
		ST_NONINC = 2'd2,
		ST_OVF = 2'd3
	} status_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EVAL = 1'b1
	} op_t;

	// item handed from the front to the back
	typedef struct packed {
		logic op;
		logic [IdxW-1:0] point_index;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
	} item_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_RD_FIRST,
		BK_RD_LAST,
		BK_CHK_ENDS,
		BK_SEARCH_RD,
		BK_SEARCH_CMP,
		BK_RD_SEG_LO,
		BK_RD_SEG_HI,
		BK_PREP,
		BK_MUL,
		BK_DIV,
		BK_ROUND,
		BK_DONE
	} bk_state_t;
endpackage

// ===== sv/table_linear_interpolator.sv =====
// top level of the table linear interpolator
// An item is taken when start is high and busy is low; a two-entry queue
// lets items arrive while an evaluate is running. A load is written to the
// table as it leaves the queue and gives no result. An evaluate reads the
// two table end points, runs a binary search of up to six single-port table
// reads, then one multiply and a 64-bit restoring divide at one bit per
// cycle, and the divider sets the rate; clamped and error queries finish
// earlier. Each result shows for one cycle with result_valid high and cannot
// be held off.
// The back clamps point_count to the table depth of 64.
module table_linear_interpolator (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic op,
	input logic [5:0] point_index,
	input logic signed [31:0] x_value,
	input logic signed [31:0] y_value,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [6:0] cfg_data,
	output logic result_valid,
	output logic signed [31:0] y_result,
	output logic [1:0] status
);
	import tli_pkg::*;

	logic [CntW-1:0] point_count_q;
	logic q_valid, q_pop, idle;
	item_t q_item;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) point_count_q <= '0;
		else if (cfg_valid && cfg_ready) point_count_q <= cfg_data;
	end

	tli_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_index(point_index), .x_value(x_value), .y_value(y_value),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	tli_back u_back (
		.clk(clk), .arst_n(arst_n), .point_count(point_count_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .idle(idle),
		.result_valid(result_valid), .y_result(y_result), .status(status)
	);

	// the back only pops from a queue that holds an item
	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_valid)
		else $error("pop from empty queue");
	// a result only appears when the back was working
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !$past(idle))
		else $error("result while idle");
	// results never come back to back
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back results");
endmodule

// ===== sv/tli_front.sv =====
// front: accepts items and queues them for the back
module tli_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic op,
	input logic [tli_pkg::IdxW-1:0] point_index,
	input logic signed [31:0] x_value,
	input logic signed [31:0] y_value,
	output logic q_valid,
	output tli_pkg::item_t q_item,
	input logic q_pop
);
	import tli_pkg::*;

	item_t mem_q [QDepth];
	logic [$clog2(QDepth)-1:0] wr_q, rd_q;
	logic [$clog2(QDepth):0] cnt_q;
	logic push;

	// queue is full when all slots are taken
	assign busy = (cnt_q == ($clog2(QDepth)+1)'(QDepth));
	assign push = start && !busy;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= '{op: op, point_index: point_index,
			x_value: x_value, y_value: y_value};
	end
endmodule

// ===== sv/tli_back.sv =====
// back: table store, binary search, multiply and serial divide
module tli_back (
	input logic clk,
	input logic arst_n,
	input logic [tli_pkg::CntW-1:0] point_count,
	input logic q_valid,
	input tli_pkg::item_t q_item,
	output logic q_pop,
	output logic idle,
	output logic result_valid,
	output logic signed [31:0] y_result,
	output logic [1:0] status
);
	import tli_pkg::*;

	logic signed [31:0] xmem [MaxPoints];
	logic signed [31:0] ymem [MaxPoints];
	logic [IdxW-1:0] raddr;
	logic signed [31:0] xrd_q, yrd_q;

	bk_state_t state_q, state_d;
	logic signed [31:0] qx_q, x0_q, y0_q, x1_q, y1_q;
	logic [IdxW:0] lo_q, hi_q, n_q;
	logic neg_q;
	logic [32:0] dx_q;
	logic [64:0] prod_q;
	logic [64:0] quo_q;
	logic [33:0] rem_q;
	logic [6:0] bit_q;
	logic [IdxW:0] mid;
	logic [IdxW:0] n_eff;
	logic signed [32:0] dxs, xos, yrs;
	logic [32:0] amag;
	logic [31:0] bmag;
	logic [34:0] rem_sh;
	logic [33:0] rem_sub;
	logic [64:0] q_rnd;
	logic signed [33:0] ysum;
	logic ovf;
	logic fire;

	assign n_eff = (point_count > CntW'(MaxPoints)) ? (IdxW+1)'(MaxPoints)
		: (IdxW+1)'(point_count);
	assign mid = (lo_q + hi_q) >> 1;

	// read address follows the state being entered
	always_comb begin
		raddr = '0;
		unique case (state_d)
			BK_RD_LAST: raddr = IdxW'(n_q - 1'b1);
			BK_SEARCH_CMP: raddr = mid[IdxW-1:0];
			BK_RD_SEG_HI: raddr = hi_q[IdxW-1:0];
			BK_PREP: raddr = hi_q[IdxW-1:0];
			BK_RD_SEG_LO: raddr = lo_q[IdxW-1:0];
			default: raddr = '0;
		endcase
	end

	// table store, one write and one registered read
	always_ff @(posedge clk) begin
		if (state_q == BK_IDLE && q_valid && q_item.op == OP_LOAD) begin
			xmem[q_item.point_index] <= q_item.x_value;
			ymem[q_item.point_index] <= q_item.y_value;
		end
		xrd_q <= xmem[raddr];
		yrd_q <= ymem[raddr];
	end

	assign dxs = 33'(x1_q) - 33'(x0_q);
	assign xos = 33'(qx_q) - 33'(x0_q);
	assign yrs = 33'(y1_q) - 33'(y0_q);
	assign amag = xos[32] ? 33'(-xos) : 33'(xos);
	assign bmag = yrs[32] ? 32'(-yrs) : 32'(yrs);
	assign ovf = (!neg_q && prod_q[64:63] != 2'b00)
		|| (neg_q && prod_q > {2'b01, 63'd0});
	assign rem_sh = {rem_q, prod_q[64 - bit_q]};
	assign rem_sub = 34'(rem_sh - 35'(dx_q));
	assign q_rnd = quo_q + ((rem_q >= 34'(dx_q) - rem_q) ? 65'd1 : 65'd0);
	assign ysum = neg_q ? 34'(y0_q) - 34'(q_rnd) : 34'(y0_q) + 34'(q_rnd);

	// sequencer next state and result strobe
	always_comb begin
		state_d = state_q;
		q_pop = 1'b0;
		fire = 1'b0;
		unique case (state_q)
			BK_IDLE: if (q_valid) begin
				q_pop = 1'b1;
				if (q_item.op == OP_EVAL) state_d = BK_RD_FIRST;
			end
			BK_RD_FIRST: begin
				if (n_q < 2) begin
					fire = 1'b1;
					state_d = BK_DONE;
				end else begin
					state_d = BK_RD_LAST;
				end
			end
			BK_RD_LAST: state_d = BK_CHK_ENDS;
			BK_CHK_ENDS: begin
				if (qx_q <= x0_q || qx_q >= x1_q) begin
					fire = 1'b1;
					state_d = BK_IDLE;
				end else begin
					state_d = BK_SEARCH_RD;
				end
			end
			BK_SEARCH_RD: state_d = (hi_q - lo_q > 1) ? BK_SEARCH_CMP : BK_RD_SEG_LO;
			BK_SEARCH_CMP: state_d = BK_SEARCH_RD;
			BK_RD_SEG_LO: state_d = BK_RD_SEG_HI;
			BK_RD_SEG_HI: state_d = BK_PREP;
			BK_PREP: state_d = BK_MUL;
			BK_MUL: begin
				if (dxs <= 0) begin
					fire = 1'b1;
					state_d = BK_IDLE;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				if (bit_q == 7'd1 && ovf) begin
					fire = 1'b1;
					state_d = BK_IDLE;
				end else if (bit_q == 7'd65) begin
					state_d = BK_ROUND;
				end
			end
			BK_ROUND: state_d = BK_DONE;
			BK_DONE: begin
				fire = (status == ST_OK);
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// sequencer registers and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			result_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			result_valid <= fire;
			unique case (state_q)
				BK_IDLE: begin
					qx_q <= q_item.x_value;
					n_q <= n_eff;
					status <= ST_OK;
					y_result <= '0;
				end
				BK_RD_FIRST: begin
					x0_q <= xrd_q;
					y0_q <= yrd_q;
					if (n_q < 2) status <= ST_FEW;
				end
				BK_RD_LAST: begin
					x1_q <= xrd_q;
					y1_q <= yrd_q;
				end
				BK_CHK_ENDS: begin
					lo_q <= '0;
					hi_q <= n_q - 1'b1;
					if (qx_q <= x0_q) y_result <= y0_q;
					else if (qx_q >= x1_q) y_result <= y1_q;
				end
				BK_SEARCH_CMP: begin
					if (qx_q < xrd_q) hi_q <= mid; else lo_q <= mid;
				end
				BK_RD_SEG_LO: begin
					x0_q <= xrd_q;
					y0_q <= yrd_q;
				end
				BK_PREP: begin
					x1_q <= xrd_q;
					y1_q <= yrd_q;
				end
				BK_MUL: begin
					if (dxs <= 0) status <= ST_NONINC;
					neg_q <= xos[32] ^ yrs[32];
					dx_q <= 33'(dxs);
					prod_q <= 65'(amag) * 65'(bmag);
					rem_q <= '0;
					quo_q <= '0;
					bit_q <= 7'd1;
				end
				BK_DIV: begin
					if (bit_q == 7'd1 && ovf) status <= ST_OVF;
					if (bit_q != 7'd65) begin
						if (rem_sh >= 35'(dx_q)) begin
							rem_q <= rem_sub;
							quo_q <= {quo_q[63:0], 1'b1};
						end else begin
							rem_q <= rem_sh[33:0];
							quo_q <= {quo_q[63:0], 1'b0};
						end
						bit_q <= bit_q + 1'b1;
					end
				end
				BK_ROUND: begin
					y_result <= ysum[31:0];
				end
				default: ;
			endcase
		end
	end

	assign idle = (state_q == BK_IDLE);
endmodule

// ===== bench/tli_checker.sv =====
// checker for the table linear interpolator: predicts each query and compares results
`timescale 1ns / 1ps
module tli_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic op,
	input logic [5:0] point_index,
	input logic signed [31:0] x_value,
	input logic signed [31:0] y_value,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [6:0] cfg_data,
	input logic result_valid,
	input logic signed [31:0] y_result,
	input logic [1:0] status,
	output int fail_count,
	output int pending,
	output int result_count
);
	import tli_pkg::*;

	typedef struct {
		logic signed [31:0] y_exp;
		status_t st_exp;
	} answer_t;

	logic signed [31:0] table_x [MaxPoints];
	logic signed [31:0] table_y [MaxPoints];
	logic [CntW-1:0] used_points;
	answer_t answers [$];

	// interpolate one query over the current table
	function automatic answer_t interpolate(input logic signed [31:0] xq);
		answer_t ans;
		int n, lo, hi, mid;
		longint xv, x0, x1, y0, y1, dx, xo, yr, res;
		logic [127:0] a, b, prod, udx, q, r;
		logic neg;
		begin
			ans.y_exp = '0;
			ans.st_exp = ST_OK;
			n = used_points;
			if (n > MaxPoints) n = MaxPoints;
			xv = xq;
			if (n < 2) begin
				ans.st_exp = ST_FEW;
				return ans;
			end
			if (xv <= longint'(table_x[0])) begin
				ans.y_exp = table_y[0];
				return ans;
			end
			if (xv >= longint'(table_x[n-1])) begin
				ans.y_exp = table_y[n-1];
				return ans;
			end
			lo = 0;
			hi = n - 1;
			while (hi - lo > 1) begin
				mid = (lo + hi) / 2;
				if (xv < longint'(table_x[mid])) hi = mid;
				else lo = mid;
			end
			x0 = table_x[lo];
			x1 = table_x[hi];
			y0 = table_y[lo];
			y1 = table_y[hi];
			dx = x1 - x0;
			if (dx <= 0) begin
				ans.st_exp = ST_NONINC;
				return ans;
			end
			xo = xv - x0;
			yr = y1 - y0;
			a = 128'(xo < 0 ? -xo : xo);
			b = 128'(yr < 0 ? -yr : yr);
			neg = (xo < 0) != (yr < 0);
			prod = a * b;
			if ((!neg && prod > 128'h7FFF_FFFF_FFFF_FFFF) ||
				(neg && prod > 128'h8000_0000_0000_0000)) begin
				ans.st_exp = ST_OVF;
				return ans;
			end
			udx = 128'(dx);
			q = prod / udx;
			r = prod % udx;
			// round half away from zero on the magnitude
			if (r >= udx - r) q = q + 1;
			res = neg ? y0 - longint'(q[63:0]) : y0 + longint'(q[63:0]);
			ans.y_exp = res[31:0];
			return ans;
		end
	endfunction

	assign pending = answers.size();

	// watch config, items and results
	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		if (!arst_n) begin
			used_points <= '0;
			fail_count <= 0;
			result_count <= 0;
			answers.delete();
			for (int i = 0; i < MaxPoints; i++) begin
				table_x[i] <= '0;
				table_y[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) used_points <= cfg_data;
			if (result_valid) begin
				result_count <= result_count + 1;
				if (answers.size() == 0) begin
					$display("%0t: unexpected result y=%0d status=%0d", $time,
						y_result, status);
					fail_count <= fail_count + 1;
				end else begin
					got = answers.pop_front();
					if (got.y_exp !== y_result || got.st_exp !== status_t'(status)) begin
						$display("%0t: mismatch expected y=%0d status=%0d, actual y=%0d status=%0d",
							$time, got.y_exp, got.st_exp, y_result, status);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy) begin
				if (op_t'(op) == OP_LOAD) begin
					table_x[point_index] <= x_value;
					table_y[point_index] <= y_value;
				end else begin
					answers.push_back(interpolate(x_value));
				end
			end
		end
	end
endmodule

// ===== bench/tb_table_linear_interpolator.sv =====
// stimulus and verdict for the table linear interpolator
`timescale 1ns / 1ps
module tb_table_linear_interpolator;
	import tli_pkg::*;

	localparam int ItemTarget = 1650;
	localparam int QuietFrom = 1450;
	localparam int CycleLimit = 2000000;
	localparam int Settle = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic op = 1'b0;
	logic [5:0] point_index = '0;
	logic signed [31:0] x_value = '0;
	logic signed [31:0] y_value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [6:0] cfg_data = '0;
	logic result_valid;
	logic signed [31:0] y_result;
	logic [1:0] status;
	int fail_count, pending, result_count;
	int items_sent = 0;
	int cycles = 0;
	int phases = 0;
	int bp [64];

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	table_linear_interpolator dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_index(point_index), .x_value(x_value), .y_value(y_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .y_result(y_result), .status(status)
	);

	tli_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.point_index(point_index), .x_value(x_value), .y_value(y_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .y_result(y_result), .status(status),
		.fail_count(fail_count), .pending(pending), .result_count(result_count)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// hand one item to the block, with an occasional idle burst first
	task automatic send_item(input op_t o, input int idx, input int xv, input int yv);
		if (items_sent < QuietFrom && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		op = o;
		point_index = idx[5:0];
		x_value = xv;
		y_value = yv;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
	endtask

	// drain all results, let any load finish, then write point_count
	task automatic set_count(input int n);
		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = n[6:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		phases++;
	endtask

	// query near a random breakpoint or anywhere
	function automatic int pick_query(input int n);
		int k;
		k = $urandom_range(0, 3);
		if (n < 1 || k == 0) return $urandom;
		k = bp[$urandom_range(0, n - 1)];
		return k + $signed($urandom_range(0, 8)) - 4;
	endfunction

	// one phase: new count, full table load, then a run of queries
	task automatic run_phase();
		int n, eff, sel, evals, j, t;
		int xs [$];
		int spread;
		sel = $urandom_range(0, 19);
		if (sel == 0) n = 0;
		else if (sel == 1) n = 1;
		else if (sel == 2) n = 64;
		else if (sel == 3) n = $urandom_range(65, 127);
		else if (sel < 8) n = $urandom_range(9, 63);
		else n = $urandom_range(2, 8);
		eff = n > 64 ? 64 : n;
		set_count(n);
		xs.delete();
		spread = $urandom_range(0, 2);
		for (int i = 0; i < eff; i++) begin
			if (spread == 0) xs.push_back($signed($urandom_range(0, 2000)) - 1000);
			else xs.push_back($urandom);
		end
		xs.sort();
		for (int i = 0; i < eff; i++) bp[i] = xs[i];
		// broken tables: a swapped or repeated breakpoint
		if (eff > 2 && $urandom_range(0, 5) == 0) begin
			j = $urandom_range(0, eff - 2);
			t = bp[j];
			bp[j] = bp[j + 1];
			bp[j + 1] = ($urandom_range(0, 1) == 0) ? t : bp[j];
		end
		for (int i = 0; i < eff; i++) send_item(OP_LOAD, i, bp[i], $urandom);
		// stray loads beyond the used range
		if (eff < 64 && $urandom_range(0, 3) == 0)
			send_item(OP_LOAD, $urandom_range(eff, 63), $urandom, $urandom);
		evals = $urandom_range(10, 40);
		for (int i = 0; i < evals; i++) send_item(OP_EVAL, $urandom, pick_query(eff), $urandom);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// too few points
		send_item(OP_EVAL, 0, 0, 0);
		set_count(1);
		send_item(OP_EVAL, 63, 32'h7FFF_FFFF, 32'h8000_0000);
		// two points spanning the full range
		set_count(2);
		send_item(OP_LOAD, 0, 32'h8000_0000, 32'h8000_0000);
		send_item(OP_LOAD, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(OP_EVAL, 0, 32'h8000_0000, 0);
		send_item(OP_EVAL, 0, 32'h7FFF_FFFF, 0);
		send_item(OP_EVAL, 0, 0, 0);
		send_item(OP_EVAL, 0, -1, 0);
		// product too large for a signed 64-bit value
		send_item(OP_EVAL, 0, 32'h7FFF_FFFE, 0);
		// falling segment, rounding of halves both ways
		send_item(OP_LOAD, 0, 0, 32'h7FFF_FFFF);
		send_item(OP_LOAD, 1, 2, 32'h8000_0000);
		send_item(OP_EVAL, 0, 1, 0);
		send_item(OP_LOAD, 0, 0, 0);
		send_item(OP_LOAD, 1, 4, 3);
		send_item(OP_EVAL, 0, 1, 0);
		send_item(OP_EVAL, 0, 2, 0);
		send_item(OP_EVAL, 0, 3, 0);
		send_item(OP_LOAD, 1, 4, -3);
		send_item(OP_EVAL, 0, 2, 0);

		while (items_sent < ItemTarget) run_phase();

		@(negedge clk);
		start = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
		$display("sent %0d items over %0d table settings, checked %0d query results",
			items_sent, phases, result_count);
		if (fail_count == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
